// ===== hw/rtl/gbr_pkg.sv =====
// Shared types and constants for the glyph bitmap rasterizer.
package gbr_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int CFG_DATA_W  = COORD_WIDTH;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_PIX     = 8;
    localparam int PIX_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TWO_BIT      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RENDER_MODE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INK_BLACK    = 3'd6;

    typedef enum logic [1:0] {
        MODE_BW       = 2'd0,
        MODE_GRAY_MSB = 2'd1,
        MODE_GRAY_LSB = 2'd2,
        MODE_NONE     = 2'd3
    } t_render_mode;

    // classified byte: bit i of mask is pixel i in raster order
    typedef struct packed {
        logic [NUM_PIX-1:0] mask;
        logic               colour;
        logic               two_bit;
        logic               start;
    } t_item;

    typedef struct packed {
        logic [7:0]             width;
        logic [7:0]             height;
        logic [COORD_WIDTH-1:0] origin_x;
        logic [COORD_WIDTH-1:0] origin_y;
    } t_geom;

endpackage

// ===== hw/rtl/gbr_front.sv =====
// Front end: turns a bitmap byte into a draw mask and colour.
module gbr_front (
    input  logic                  i_two_bit,
    input  gbr_pkg::t_render_mode i_mode,
    input  logic                  i_ink_black,
    input  logic [7:0]            i_bitmap_byte,
    input  logic                  i_glyph_start,
    output gbr_pkg::t_item        o_item
);

    logic [gbr_pkg::NUM_PIX-1:0] mask;
    logic [1:0]                  fld [4];
    logic                        colour;

    always_comb begin
        mask   = '0;
        colour = i_ink_black;
        for (int k = 0; k < 4; k++) begin
            fld[k] = i_bitmap_byte[7-2*k -: 2];
        end
        if (i_two_bit) begin
            unique case (i_mode)
                gbr_pkg::MODE_BW: begin
                    for (int k = 0; k < 4; k++) mask[k] = (fld[k] != 2'd0);
                end
                gbr_pkg::MODE_GRAY_MSB: begin
                    colour = 1'b0;
                    for (int k = 0; k < 4; k++) mask[k] = (fld[k] == 2'd1) || (fld[k] == 2'd2);
                end
                gbr_pkg::MODE_GRAY_LSB: begin
                    colour = 1'b0;
                    for (int k = 0; k < 4; k++) mask[k] = (fld[k] == 2'd2);
                end
                gbr_pkg::MODE_NONE: begin
                    colour = 1'b0;
                end
            endcase
        end else begin
            for (int k = 0; k < gbr_pkg::NUM_PIX; k++) mask[k] = i_bitmap_byte[7-k];
        end
    end

    assign o_item.mask    = mask;
    assign o_item.colour  = colour;
    assign o_item.two_bit = i_two_bit;
    assign o_item.start   = i_glyph_start;

endmodule

// ===== hw/rtl/gbr_queue.sv =====
// Two-entry queue between front and back end.
module gbr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  gbr_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output gbr_pkg::t_item o_item
);

    gbr_pkg::t_item r_mem [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_item;
    end

    assign o_full  = r_count[1];
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rptr];

endmodule

// ===== hw/rtl/gbr_back.sv =====
// Back end: walks the pixels of one byte, tracks position, emits pixel writes.
module gbr_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  gbr_pkg::t_geom                 i_geom,
    input  logic                           i_q_valid,
    input  gbr_pkg::t_item                 i_q_item,
    output logic                           o_q_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [gbr_pkg::COORD_WIDTH:0]  o_pixel_x,
    output logic [gbr_pkg::COORD_WIDTH:0]  o_pixel_y,
    output logic                           o_pixel_value,
    output logic                           o_last_of_byte
);

    logic [gbr_pkg::PIX_IDX_W-1:0] r_idx;
    logic [7:0]                    r_col;
    logic [8:0]                    r_row;
    logic                          r_out_valid;
    logic [gbr_pkg::COORD_WIDTH:0] r_x;
    logic [gbr_pkg::COORD_WIDTH:0] r_y;
    logic                          r_val;
    logic                          r_last;

    logic [7:0]                    e_col;
    logic [8:0]                    e_row;
    logic                          active;
    logic                          draw;
    logic                          out_free;
    logic                          step;
    logic                          emit;
    logic                          byte_done;
    logic [gbr_pkg::PIX_IDX_W-1:0] last_idx;
    logic [gbr_pkg::NUM_PIX-1:0]   ahead;
    logic [gbr_pkg::PIX_IDX_W-1:0] hop;
    logic                          found;
    logic [7:0]                    rows_left;
    logic [15:0]                   prod;
    logic [8:0]                    tail;
    logic [16:0]                   remaining;
    logic                          last;
    logic [8:0]                    col_inc;
    logic [7:0]                    n_col;
    logic [8:0]                    n_row;

    always_comb begin
        e_col = (r_idx == '0 && i_q_item.start) ? 8'd0 : r_col;
        e_row = (r_idx == '0 && i_q_item.start) ? 9'd0 : r_row;
        active = (i_geom.width != 8'd0) && (e_row < {1'b0, i_geom.height});
        draw = i_q_item.mask[r_idx];
        last_idx = i_q_item.two_bit ? gbr_pkg::PIX_IDX_W'(3) : gbr_pkg::PIX_IDX_W'(7);
        byte_done = !active || (r_idx == last_idx);
        out_free = !r_out_valid || i_out_ready;
        step = i_q_valid && (!active || !draw || out_free);
        emit = step && active && draw;

        // next drawn pixel of this byte, if any
        ahead = i_q_item.mask >> r_idx;
        hop   = '0;
        found = 1'b0;
        for (int k = gbr_pkg::NUM_PIX - 1; k >= 1; k--) begin
            if (ahead[k]) begin
                hop   = gbr_pkg::PIX_IDX_W'(k);
                found = 1'b1;
            end
        end

        // pixels left in the glyph, counting the current one
        rows_left = i_geom.height - 8'd1 - e_row[7:0];
        prod      = 16'(rows_left) * 16'(i_geom.width);
        tail      = (e_col < i_geom.width) ? (9'(i_geom.width) - 9'(e_col)) : 9'd1;
        remaining = 17'(prod) + 17'(tail);
        last      = !(found && (remaining > 17'(hop)));

        col_inc = 9'(e_col) + 9'd1;
        if (col_inc >= 9'(i_geom.width)) begin
            n_col = 8'd0;
            n_row = e_row + 9'd1;
        end else begin
            n_col = col_inc[7:0];
            n_row = e_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_col       <= 8'd0;
            r_row       <= 9'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_idx <= byte_done ? '0 : r_idx + gbr_pkg::PIX_IDX_W'(1);
                if (active) begin
                    r_col <= n_col;
                    r_row <= n_row;
                end else begin
                    r_col <= e_col;
                    r_row <= e_row;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_x    <= {i_geom.origin_x[gbr_pkg::COORD_WIDTH-1], i_geom.origin_x}
                      + (gbr_pkg::COORD_WIDTH+1)'(e_col);
            r_y    <= {i_geom.origin_y[gbr_pkg::COORD_WIDTH-1], i_geom.origin_y}
                      + (gbr_pkg::COORD_WIDTH+1)'(e_row);
            r_val  <= i_q_item.colour;
            r_last <= last;
        end
    end

    assign o_q_pop        = step && byte_done;
    assign o_out_valid    = r_out_valid;
    assign o_pixel_x      = r_x;
    assign o_pixel_y      = r_y;
    assign o_pixel_value  = r_val;
    assign o_last_of_byte = r_last;

endmodule

// ===== hw/rtl/glyph_bitmap_rasterizer_unit.sv =====
// Top level of the glyph bitmap rasterizer: config registers, front, queue, back.
//
//  channel  direction  handshake                 payload
//  in       input      i_in_valid / o_in_ready   i_bitmap_byte, i_glyph_start
//  out      output     o_out_valid / i_out_ready o_pixel_x, o_pixel_y, o_pixel_value,
//                                                o_last_of_byte
//  cfg      input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// The back end walks one pixel per cycle while not stalled: eight pixels per 1-bit byte,
// four per 2-bit byte; a byte past the end of the glyph is popped without being walked.
// Bytes are taken while the two-entry queue has room; the back end stalls only
// when it must write a pixel and the output register is still held.
// Reset is synchronous and holds o_in_ready low; no clearing pass.
module glyph_bitmap_rasterizer_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gbr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gbr_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [7:0]                       i_bitmap_byte,
    input  logic                             i_glyph_start,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [gbr_pkg::COORD_WIDTH:0] o_pixel_x,
    output logic signed [gbr_pkg::COORD_WIDTH:0] o_pixel_y,
    output logic                             o_pixel_value,
    output logic                             o_last_of_byte
);

    logic [7:0]                     r_width;
    logic [7:0]                     r_height;
    logic [gbr_pkg::COORD_WIDTH-1:0] r_origin_x;
    logic [gbr_pkg::COORD_WIDTH-1:0] r_origin_y;
    logic                           r_two_bit;
    gbr_pkg::t_render_mode          r_mode;
    logic                           r_ink_black;

    gbr_pkg::t_item front_item;
    gbr_pkg::t_item q_item;
    gbr_pkg::t_geom geom;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    logic           push;
    logic [gbr_pkg::COORD_WIDTH:0] pix_x;
    logic [gbr_pkg::COORD_WIDTH:0] pix_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= 8'd0;
            r_height    <= 8'd0;
            r_origin_x  <= '0;
            r_origin_y  <= '0;
            r_two_bit   <= 1'b0;
            r_mode      <= gbr_pkg::MODE_BW;
            r_ink_black <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gbr_pkg::REG_GLYPH_WIDTH:  r_width     <= i_cfg_data[7:0];
                gbr_pkg::REG_GLYPH_HEIGHT: r_height    <= i_cfg_data[7:0];
                gbr_pkg::REG_ORIGIN_X:     r_origin_x  <= i_cfg_data[gbr_pkg::COORD_WIDTH-1:0];
                gbr_pkg::REG_ORIGIN_Y:     r_origin_y  <= i_cfg_data[gbr_pkg::COORD_WIDTH-1:0];
                gbr_pkg::REG_TWO_BIT:      r_two_bit   <= i_cfg_data[0];
                gbr_pkg::REG_RENDER_MODE:  r_mode      <= gbr_pkg::t_render_mode'(i_cfg_data[1:0]);
                gbr_pkg::REG_INK_BLACK:    r_ink_black <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign geom.width    = r_width;
    assign geom.height   = r_height;
    assign geom.origin_x = r_origin_x;
    assign geom.origin_y = r_origin_y;

    assign o_in_ready = i_rst_n && !q_full;
    assign push       = i_in_valid && o_in_ready;

    gbr_front u_front (
        .i_two_bit     (r_two_bit),
        .i_mode        (r_mode),
        .i_ink_black   (r_ink_black),
        .i_bitmap_byte (i_bitmap_byte),
        .i_glyph_start (i_glyph_start),
        .o_item        (front_item)
    );

    gbr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    gbr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_geom         (geom),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_x      (pix_x),
        .o_pixel_y      (pix_y),
        .o_pixel_value  (o_pixel_value),
        .o_last_of_byte (o_last_of_byte)
    );

    assign o_pixel_x = signed'(pix_x);
    assign o_pixel_y = signed'(pix_y);

endmodule
